>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the row mirror sepia filter.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/rmsf_pkg.sv
// Types and constants of the row mirror sepia filter.
// No dependencies; used by rmsf_tone and the top level.
package rmsf_pkg;

  // Configuration register indexes and widths
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;
  localparam int ROW_W_BITS    = 7;
  localparam int ROW_W_RESET   = 64;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIRROR    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEPIA     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH = 2'd2;

  // Sepia arithmetic: dot product, reciprocal divide, clamp
  localparam int SUM_BITS    = 19;
  localparam int PROD_BITS   = 30;
  localparam int Q_BITS      = 9;
  localparam int DIVISOR     = 1000;
  localparam int RECIP       = 1048;  // floor(2^20 / 1000)
  localparam int RECIP_SHIFT = 20;
  localparam int CLAMP_MAX   = 255;

  localparam int SEPIA_M [3][3] = '{'{393, 769, 189},
                                    '{349, 686, 168},
                                    '{272, 534, 131}};

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
  } pix_out_t;

  // One pixel handed to the tone pipeline
  typedef struct packed {
    pix_in_t pix;
    logic    row_end;
    logic    sepia;
  } tone_item_t;

  function automatic logic [SUM_BITS-1:0] dot3(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input int ka,
                                               input int kb, input int kc);
    return SUM_BITS'(ka) * SUM_BITS'(a) + SUM_BITS'(kb) * SUM_BITS'(b)
         + SUM_BITS'(kc) * SUM_BITS'(c);
  endfunction

endpackage

>>> rtl/rmsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
module rmsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rmsf_tone.sv
// Sepia tone pipeline with output register: dot product, reciprocal divide, clamp, or bypass.
// Depends on rmsf_pkg.
module rmsf_tone (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rmsf_pkg::tone_item_t item,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output rmsf_pkg::pix_out_t  out_pixel
);

  localparam int SB = rmsf_pkg::SUM_BITS;
  localparam int QB = rmsf_pkg::Q_BITS;
  localparam int RS = rmsf_pkg::RECIP_SHIFT;

  logic                 v1, v2;
  logic [2:0][SB-1:0]   sum_c;
  logic [2:0][SB-1:0]   s1_sum, s2_sum;
  rmsf_pkg::pix_in_t    s1_pix, s2_pix;
  logic                 s1_end, s2_end, s1_sep, s2_sep;
  logic [2:0][QB-1:0]   q0_c, s2_q0;
  logic [2:0][7:0]      tone_c;

  logic [rmsf_pkg::PROD_BITS-1:0] prod [3];
  logic [SB-1:0]                  rem [3];
  logic [QB-1:0]                  q   [3];

  // Advance all stages together whenever the output slot frees up
  assign adv = !out_valid || !out_stall;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = rmsf_pkg::dot3(item.pix.in_red, item.pix.in_green, item.pix.in_blue,
                                 rmsf_pkg::SEPIA_M[ch][0], rmsf_pkg::SEPIA_M[ch][1],
                                 rmsf_pkg::SEPIA_M[ch][2]);
      prod[ch]  = rmsf_pkg::PROD_BITS'(s1_sum[ch])
                * rmsf_pkg::PROD_BITS'(rmsf_pkg::RECIP);
      q0_c[ch]  = prod[ch][RS+QB-1:RS];
      // Reciprocal quotient is exact or one low; fix with one compare
      rem[ch]   = s2_sum[ch] - SB'(s2_q0[ch]) * SB'(rmsf_pkg::DIVISOR);
      q[ch]     = (rem[ch] >= SB'(rmsf_pkg::DIVISOR)) ? s2_q0[ch] + 1'b1 : s2_q0[ch];
      tone_c[ch] = (q[ch] > QB'(rmsf_pkg::CLAMP_MAX)) ? 8'(rmsf_pkg::CLAMP_MAX) : q[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= push;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum <= sum_c;
      s1_pix <= item.pix;
      s1_end <= item.row_end;
      s1_sep <= item.sepia;
      s2_sum <= s1_sum;
      s2_q0  <= q0_c;
      s2_pix <= s1_pix;
      s2_end <= s1_end;
      s2_sep <= s1_sep;
      if (s2_sep) begin
        out_pixel.out_red   <= tone_c[0];
        out_pixel.out_green <= tone_c[1];
        out_pixel.out_blue  <= tone_c[2];
      end else begin
        out_pixel.out_red   <= s2_pix.in_red;
        out_pixel.out_green <= s2_pix.in_green;
        out_pixel.out_blue  <= s2_pix.in_blue;
      end
      out_pixel.row_end <= s2_end;
    end
  end

endmodule

>>> rtl/row_mirror_sepia_filter_core.sv
// Top level of the row mirror sepia filter: column control, line buffer, burst reader.
// Depends on rmsf_pkg, rmsf_ram, rmsf_tone and assert_macros.svh.
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_pixel     | one RGB pixel per transaction
//   output  | out_valid, out_stall, out_pixel  | one result pixel + row_end
//   config  | cfg_en, cfg_index, cfg_data      | one register write, no wait
//
// Mirror off: one pixel per cycle while the output flows, via s1, s2 and the output register.
// Mirror on: the W pixels of a row are written first, then a burst that
//   reads the line buffer once a cycle unless stalled, on its single read port.
// Reset clears control state only; the line buffer needs no clearing pass.
// An output stall freezes the tone pipeline and, behind it, burst reads and input.
`include "assert_macros.svh"

module row_mirror_sepia_filter_core #(
  parameter int MAX_ROW_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rmsf_pkg::pix_in_t                    in_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rmsf_pkg::pix_out_t                   out_pixel,
  input  logic                                 cfg_en,
  input  logic [rmsf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rmsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_ROW_WIDTH);
  localparam int WB = rmsf_pkg::ROW_W_BITS;

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  state_t                state;
  logic                  mirror_enable;
  logic                  sepia_enable;
  logic [WB-1:0]         row_width;
  logic [CW-1:0]         col;
  logic [CW-1:0]         rd_idx;
  logic                  rd_valid;
  logic                  rd_end;
  logic [23:0]           rd_data;

  logic [WB-1:0]         w_eff;
  logic                  last;
  logic                  accept;
  logic                  issue;
  logic                  adv;
  logic                  push;
  rmsf_pkg::tone_item_t  item;

  // Clamp the configured width into 1..MAX_ROW_WIDTH
  always_comb begin
    if (row_width == '0) begin
      w_eff = WB'(1);
    end else if (row_width > WB'(MAX_ROW_WIDTH)) begin
      w_eff = WB'(MAX_ROW_WIDTH);
    end else begin
      w_eff = row_width;
    end
  end

  // A column at or past the last one ends the row, also after a width shrink
  assign last = WB'(col) >= (w_eff - WB'(1));

  // Take input only with the read slot drained, so burst and direct pixels never mix
  assign in_stall = !(state == ST_IDLE && adv && !rd_valid);
  assign accept   = in_valid && !in_stall;

  // Issue a burst read whenever the read slot is empty or drains this cycle
  assign issue = (state == ST_BURST) && (!rd_valid || adv);

  assign push         = (rd_valid && adv) || (accept && !mirror_enable);
  assign item.pix     = rd_valid ? rmsf_pkg::pix_in_t'(rd_data) : in_pixel;
  assign item.row_end = rd_valid ? rd_end : last;
  assign item.sepia   = sepia_enable;

  // Every pixel lands in the line buffer; the burst starts the cycle after the
  // row's last write, so the read of that entry sees the new data
  rmsf_ram #(
    .WIDTH(24),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(in_pixel),
    .re   (issue),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  rmsf_tone u_tone (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .adv      (adv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel(out_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mirror_enable <= 1'b0;
      sepia_enable  <= 1'b0;
      row_width     <= WB'(rmsf_pkg::ROW_W_RESET);
      col           <= '0;
      rd_idx        <= '0;
      rd_valid      <= 1'b0;
      rd_end        <= 1'b0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          rmsf_pkg::CFG_MIRROR:    mirror_enable <= cfg_data[0];
          rmsf_pkg::CFG_SEPIA:     sepia_enable  <= cfg_data[0];
          rmsf_pkg::CFG_ROW_WIDTH: row_width     <= cfg_data[WB-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            col <= last ? '0 : col + 1'b1;
            if (mirror_enable && last) begin
              // Release the row from the column just written down to zero
              state  <= ST_BURST;
              rd_idx <= col;
            end
          end
        end
        ST_BURST: begin
          if (issue) begin
            rd_end <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx - 1'b1;
            end
          end
        end
      endcase

      // Hold the read slot until the pipeline takes it
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (adv) begin
        rd_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_rd_hold, clk, rst, (rd_valid && !adv) |=> $stable(rd_data))
  `ASSERT_CLK(a_rd_last, clk, rst, (issue && rd_idx == '0) |=> (rd_valid && rd_end))
  `ASSERT_CLK(a_burst_start, clk, rst, (accept && mirror_enable && last) |=> (state == ST_BURST && rd_idx == $past(col)))

endmodule

>>> tb/sv/rmsf_pixel_checker.sv
// Checker for the row mirror sepia filter: watches the pixel, result and register channels.
// Predicts result pixels from accepted pixels and compares them. Depends on rmsf_pkg.
module rmsf_pixel_checker #(
  parameter int MAX_ROW_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  rmsf_pkg::pix_in_t                  in_pixel,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  rmsf_pkg::pix_out_t                 out_pixel,
  input  logic                               cfg_en,
  input  logic [rmsf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rmsf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 results_checked
);
  import rmsf_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [23:0]              row_buffer [MAX_ROW_WIDTH];
  logic [5:0]               column;
  logic                     mirror_on;
  logic                     sepia_on;
  logic [CFG_DATA_BITS-1:0] width_reg;
  pix_out_t                 expected_pixels [$];
  int                       bad_results;
  int                       result_index;

  // floor(k . rgb / 1000), clamped to 8 bits
  function automatic logic [7:0] sepia_channel(input logic [23:0] rgb, input int kr,
                                               input int kg, input int kb);
    int sum;
    sum = (kr * rgb[23:16] + kg * rgb[15:8] + kb * rgb[7:0]) / 1000;
    return (sum > 255) ? 8'd255 : 8'(sum);
  endfunction

  function automatic void queue_result(input logic [23:0] rgb, input logic last);
    pix_out_t want;
    if (sepia_on) begin
      want.out_red   = sepia_channel(rgb, 393, 769, 189);
      want.out_green = sepia_channel(rgb, 349, 686, 168);
      want.out_blue  = sepia_channel(rgb, 272, 534, 131);
    end else begin
      {want.out_red, want.out_green, want.out_blue} = rgb;
    end
    want.row_end = last;
    expected_pixels.push_back(want);
  endfunction

  function automatic void predict_pixel(input pix_in_t px);
    logic [6:0] eff_width;
    logic       last;
    if (width_reg == '0)
      eff_width = 7'd1;
    else if (width_reg > MAX_ROW_WIDTH)
      eff_width = 7'(MAX_ROW_WIDTH);
    else
      eff_width = width_reg;
    // A column at or past the last one closes the row, even after a width shrink
    last = ({1'b0, column} >= eff_width - 7'd1);
    row_buffer[column] = px;
    if (!mirror_on) begin
      queue_result(px, last);
    end else if (last) begin
      for (int i = column; i >= 0; i--) queue_result(row_buffer[i], i == 0);
    end
    column = last ? 6'd0 : column + 6'd1;
  endfunction

  function automatic void check_result(input pix_out_t got);
    pix_out_t want;
    result_index++;
    if (expected_pixels.size() == 0) begin
      bad_results++;
      if (bad_results <= REPORT_MAX)
        $display("result %0d: nothing expected, got r=%02h g=%02h b=%02h end=%0b",
                 result_index, got.out_red, got.out_green, got.out_blue, got.row_end);
      return;
    end
    want = expected_pixels.pop_front();
    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
        got.out_blue !== want.out_blue || got.row_end !== want.row_end) begin
      bad_results++;
      if (bad_results <= REPORT_MAX)
        $display("result %0d: expected r=%02h g=%02h b=%02h end=%0b, got r=%02h g=%02h b=%02h end=%0b",
                 result_index, want.out_red, want.out_green, want.out_blue, want.row_end,
                 got.out_red, got.out_green, got.out_blue, got.row_end);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_pixels.delete();
      column    = '0;
      mirror_on = 1'b0;
      sepia_on  = 1'b0;
      width_reg = 7'(MAX_ROW_WIDTH);
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_MIRROR:    mirror_on = cfg_data[0];
          CFG_SEPIA:     sepia_on  = cfg_data[0];
          CFG_ROW_WIDTH: width_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixel(in_pixel);
      if (out_valid && !out_stall) check_result(out_pixel);
    end
    pending         <= expected_pixels.size();
    mismatches      <= bad_results;
    results_checked <= result_index;
  end

endmodule

>>> tb/sv/row_mirror_sepia_filter_core_test.sv
// Testbench top for row_mirror_sepia_filter_core: clock, reset, pixel and register stimulus.
// Depends on rmsf_pkg, the core and rmsf_pixel_checker, which predicts and compares.
module row_mirror_sepia_filter_core_test;
  import rmsf_pkg::*;

  localparam int ROW_MAX       = 64;
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int TARGET_PIXELS = 480;
  // Quiet stretch after the last result before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  // Cycles in a row with no transaction on either channel before giving up
  localparam int QUIET_LIMIT   = 2000;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  pix_in_t                  in_pixel  = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_en    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_stall;
  logic                     out_valid;
  pix_out_t                 out_pixel;

  int          mismatches;
  int          pending;
  int          results_checked;
  int          pixels_sent = 0;
  int          reg_writes  = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          stall_tick  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  row_mirror_sepia_filter_core #(
    .MAX_ROW_WIDTH(ROW_MAX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rmsf_pixel_checker #(
    .MAX_ROW_WIDTH(ROW_MAX)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Result-side back-pressure: when the mode counter runs out, switch to a random stall
  // style, so stalls land on every phase of a row burst, with clean stretches in between.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 5 >= 3);
      // Toggle rarely: long runs of stall and of flow
      STALL_LONG:     out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
      default:        out_stall <= 1'b0;
    endcase
  end

  // Watchdog: a hung block shows up as a long run with no transaction anywhere.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results still expected",
               quiet_cycles, pending);
      $display("row_mirror_sepia_filter_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One pixel transaction. The sender runs in bursts; at the end of a burst drop
  // valid for a random gap (sometimes none), then hold the pixel until accepted.
  task automatic send_pixel(input pix_in_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Drop valid and wait until every predicted result is out, plus a margin for a
  // pixel that wrote the line buffer without releasing anything.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    reg_writes++;
  endtask

  // Write all three registers back to back; only bit 0 of the enables counts,
  // so fill the upper data bits with noise.
  task automatic load_config(input logic mirror, input logic sepia,
                             input logic [CFG_DATA_BITS-1:0] width);
    write_reg(CFG_MIRROR, {(CFG_DATA_BITS-1)'($urandom), mirror});
    write_reg(CFG_SEPIA,  {(CFG_DATA_BITS-1)'($urandom), sepia});
    write_reg(CFG_ROW_WIDTH, width);
    cfg_en <= 1'b0;
  endtask

  // Channel value biased toward the extremes
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_BITS-1:0] width;
    int                       eff_width;
    int                       count;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: plain pass-through, width 64
    send_pixel(pix_in_t'(24'h000000));
    send_pixel(pix_in_t'(24'hFFFFFF));
    send_pixel(pix_in_t'(24'h80017F));

    // Sepia on mid-row: red and green saturate on white, blue stays under the clamp
    settle();
    load_config(1'b0, 1'b1, 7'd64);
    send_pixel(pix_in_t'(24'hFFFFFF));
    send_pixel(pix_in_t'(24'h000000));
    send_pixel(pix_in_t'(24'hFF0000));
    send_pixel(pix_in_t'(24'h00FF00));
    send_pixel(pix_in_t'(24'h0000FF));

    // Mirror on mid-row together with a width below the current column:
    // the next pixel closes the row and releases everything stored so far
    settle();
    load_config(1'b1, 1'b0, 7'd4);
    send_pixel(pix_in_t'(24'h5AA53C));

    // Width zero acts as one, mirrored and plain
    settle();
    load_config(1'b1, 1'b1, 7'd0);
    send_pixel(pix_in_t'(24'h123456));
    send_pixel(pix_in_t'(24'hFEDCBA));
    settle();
    load_config(1'b0, 1'b0, 7'd0);
    send_pixel(pix_in_t'(24'hA5A5A5));
    send_pixel(pix_in_t'(24'h5A5A5A));

    // Width above the maximum acts as the maximum
    settle();
    load_config(1'b0, 1'b1, 7'd127);
    send_pixel(pix_in_t'(24'hC0FFEE));
    send_pixel(pix_in_t'(24'h0F0F0F));

    // Short mirrored rows; the last pixel leaves a row open with nothing released
    settle();
    load_config(1'b1, 1'b1, 7'd2);
    send_pixel(pix_in_t'(24'h010203));
    send_pixel(pix_in_t'(24'hF0E0D0));
    send_pixel(pix_in_t'(24'h7F8081));
    send_pixel(pix_in_t'(24'h808080));

    // Random phases: mostly whole rows at a random setting, sometimes a ragged
    // tail so that the next setting lands mid-row
    while (pixels_sent < TARGET_PIXELS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       width = 7'd1;
        1:       width = 7'(ROW_MAX);
        2:       width = 7'd0;
        3:       width = 7'($urandom_range(ROW_MAX + 1, 127));
        4, 5:    width = 7'($urandom_range(17, ROW_MAX - 1));
        default: width = 7'($urandom_range(1, 16));
      endcase
      load_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), width);
      eff_width = (width == 0) ? 1 : (width > ROW_MAX) ? ROW_MAX : int'(width);
      count = eff_width * ((eff_width >= 32) ? 1 : $urandom_range(1, 48 / eff_width + 1));
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff_width);
      repeat (count) send_pixel({pick_level(), pick_level(), pick_level()});
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pixels sent over %0d register writes, %0d result pixels checked",
             pixels_sent, reg_writes, results_checked);
    $display("covered: pass-through, mirror, sepia clamp, widths 0/1/64/above max, mid-row changes");
    if (mismatches == 0)
      $display("row_mirror_sepia_filter_core_test: done, clean");
    else
      $display("row_mirror_sepia_filter_core_test: done, errors");
    $finish;
  end

endmodule

>>> row_mirror_sepia_filter_core.f
+incdir+rtl
rtl/rmsf_pkg.sv
rtl/rmsf_ram.sv
rtl/rmsf_tone.sv
rtl/row_mirror_sepia_filter_core.sv
tb/sv/rmsf_pixel_checker.sv
tb/sv/row_mirror_sepia_filter_core_test.sv
